### rtl/dmbtd_pkg.sv
// ----------------------------------------------------------------------------
// DVB MJD/BCD time decoder package
// Shared types, constants and the month start and BCD decode functions of the decoder.
// ----------------------------------------------------------------------------
package dmbtd_pkg;

   // Stages from the input register to the output register.
   localparam int NUM_STAGES = 7;

   // Configuration register indexes.
   localparam logic CSR_ZONE_WEST_SECONDS = 1'b0;
   localparam logic CSR_LOCAL_MODE        = 1'b1;

   // Day counting constants. The date is counted from 1600-03-01, the start
   // of a 400-year Gregorian cycle; MJD 51604 is 2000-03-01.
   localparam logic [15:0] MJD_ERA_ONE      = 16'd51604;
   localparam logic [17:0] DOE_ERA_ZERO_ADD = 18'd94493;
   localparam logic [17:0] DAYS_PER_ERA_M1  = 18'd146096;
   localparam logic [17:0] DAYS_PER_CENTURY = 18'd36524;
   localparam logic [10:0] YEAR_BASE        = 11'd1600;
   localparam logic [10:0] YEARS_PER_ERA    = 11'd400;
   localparam logic [15:0] MJD_FORMULA_MIN  = 16'd15079;
   localparam logic [16:0] MJD_UNIX_EPOCH   = 17'd40587;
   localparam logic [33:0] SECONDS_PER_DAY  = 34'd86400;

   // Reciprocals for exact division by constants: q = (x * MUL) >> SHIFT,
   // with the shift chosen so that divisor times the largest x is below 2**SHIFT.
   localparam int DIV1460_SHIFT = 28;
   localparam logic [17:0] DIV1460_MUL =
      18'(((64'd1 << DIV1460_SHIFT) + 64'd1459) / 64'd1460);
   localparam int DIV365_SHIFT = 26;
   localparam logic [17:0] DIV365_MUL =
      18'(((64'd1 << DIV365_SHIFT) + 64'd364) / 64'd365);
   localparam int DIV153_SHIFT = 19;
   localparam logic [11:0] DIV153_MUL =
      12'(((64'd1 << DIV153_SHIFT) + 64'd152) / 64'd153);

   typedef struct packed {
      logic signed [16:0] zone_west_seconds;
      logic               local_mode;
   } cfg_type;

   typedef struct packed {
      logic [NUM_STAGES-1:0] load;
   } pipe_ctrl_type;

   typedef struct packed {
      logic [15:0] julian_day;
      logic        era;
      logic [17:0] doe;
      logic [7:0]  hour_bin;
      logic [7:0]  minute_bin;
      logic [7:0]  second_bin;
      logic        time_present;
      logic        date_in_range;
   } front_type;

   typedef struct packed {
      logic [10:0] year_full;
      logic [3:0]  month_number;
      logic [4:0]  day_of_month;
   } date_type;

   typedef struct packed {
      logic signed [32:0] epoch_seconds;
      logic [7:0]         hour_bin;
      logic [7:0]         minute_bin;
      logic [7:0]         second_bin;
      logic               time_present;
      logic               date_in_range;
   } time_type;

   // Day of the year (counted from March 1) on which a month starts; the
   // index counts months from March.
   function automatic logic [8:0] month_start(input logic [3:0] mp);
      logic [8:0] r;
      unique case (mp)
         4'd0:    r = 9'd0;
         4'd1:    r = 9'd31;
         4'd2:    r = 9'd61;
         4'd3:    r = 9'd92;
         4'd4:    r = 9'd122;
         4'd5:    r = 9'd153;
         4'd6:    r = 9'd184;
         4'd7:    r = 9'd214;
         4'd8:    r = 9'd245;
         4'd9:    r = 9'd275;
         4'd10:   r = 9'd306;
         4'd11:   r = 9'd337;
         default: r = 9'd0;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] bcd_to_bin(input logic [7:0] b);
      return 8'({4'd0, b[7:4]} * 8'd10) + {4'd0, b[3:0]};
   endfunction

endpackage

### rtl/dmbtd_channels.sv
// ----------------------------------------------------------------------------
// DVB MJD/BCD time decoder channels
// Valid/ready interfaces for the request and response words.
// ----------------------------------------------------------------------------
interface dmbtd_req_if;
   logic       valid;
   logic       ready;
   logic [15:0] julian_day;
   logic [7:0]  hour_bcd;
   logic [7:0]  minute_bcd;
   logic [7:0]  second_bcd;

   modport source (output valid, julian_day, hour_bcd, minute_bcd, second_bcd,
                   input ready);
   modport sink   (input valid, julian_day, hour_bcd, minute_bcd, second_bcd,
                   output ready);
endinterface

interface dmbtd_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [32:0] epoch_seconds;
   logic [10:0]        year_full;
   logic [3:0]         month_number;
   logic [4:0]         day_of_month;
   logic [7:0]         hour_bin;
   logic [7:0]         minute_bin;
   logic [7:0]         second_bin;
   logic               time_present;
   logic               date_in_range;

   modport source (output valid, epoch_seconds, year_full, month_number,
                   day_of_month, hour_bin, minute_bin, second_bin,
                   time_present, date_in_range,
                   input ready);
   modport sink   (input valid, epoch_seconds, year_full, month_number,
                   day_of_month, hour_bin, minute_bin, second_bin,
                   time_present, date_in_range,
                   output ready);
endinterface

### rtl/dvb_mjd_bcd_time_decoder_unit.sv
// ----------------------------------------------------------------------------
// DVB MJD/BCD time decoder
// Converts a DVB UTC_time field to a calendar date, binary time and epoch.
//
//   channel  direction  handshake      contents
//   req_ch   in         valid/ready    MJD and BCD hour, minute, second
//   rsp_ch   out        valid/ready    epoch, date, binary time, flags
//   csr_*    in         write enable   zone offset, local mode
//
// There are seven register stages between an accepted request word and its response
// word, and one word is taken each cycle while rsp_ch does not stall. The depth
// is set by the date path, where three reciprocal multiplies by constants and
// the corrections between them each get a stage. Reset clears the stage valid
// bits and both registers. A stall on rsp_ch holds full stages in place while
// empty stages further up keep filling.
// ----------------------------------------------------------------------------
module dvb_mjd_bcd_time_decoder_unit (
   input  logic              clock,
   input  logic              reset,
   dmbtd_req_if.sink         req_ch,
   dmbtd_rsp_if.source       rsp_ch,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [16:0]       csr_wdata
);

   localparam int LAST = dmbtd_pkg::NUM_STAGES - 1;

   logic [LAST:0]            valid_ff;
   dmbtd_pkg::cfg_type       cfg_ff;
   dmbtd_pkg::pipe_ctrl_type ctrl;
   dmbtd_pkg::front_type     front;
   dmbtd_pkg::date_type      date;
   dmbtd_pkg::time_type      tod;
   logic                     req_accept;

   // A stage may load when it is empty or when the stage after it loads.
   always_comb begin
      ctrl.load[LAST] = !valid_ff[LAST] || rsp_ch.ready;
      for (int i = LAST - 1; i >= 0; i--) begin
         ctrl.load[i] = !valid_ff[i] || ctrl.load[i+1];
      end
   end

   assign req_ch.ready = ctrl.load[0] && !reset;
   assign req_accept   = req_ch.valid && req_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         cfg_ff   <= '0;
      end else begin
         if (ctrl.load[0]) begin
            valid_ff[0] <= req_accept;
         end
         for (int i = 1; i <= LAST; i++) begin
            if (ctrl.load[i]) begin
               valid_ff[i] <= valid_ff[i-1];
            end
         end
         if (csr_we) begin
            unique case (csr_index)
               dmbtd_pkg::CSR_ZONE_WEST_SECONDS: cfg_ff.zone_west_seconds <= csr_wdata;
               dmbtd_pkg::CSR_LOCAL_MODE:        cfg_ff.local_mode <= csr_wdata[0];
               default:                          cfg_ff <= cfg_ff;
            endcase
         end
      end
   end

   dmbtd_front u_front (
      .clock      (clock),
      .ctrl       (ctrl),
      .julian_day (req_ch.julian_day),
      .hour_bcd   (req_ch.hour_bcd),
      .minute_bcd (req_ch.minute_bcd),
      .second_bcd (req_ch.second_bcd),
      .front      (front)
   );

   dmbtd_date u_date (
      .clock (clock),
      .ctrl  (ctrl),
      .front (front),
      .date  (date)
   );

   dmbtd_time u_time (
      .clock (clock),
      .ctrl  (ctrl),
      .cfg   (cfg_ff),
      .front (front),
      .tod   (tod)
   );

   assign rsp_ch.valid         = valid_ff[LAST];
   assign rsp_ch.epoch_seconds = tod.epoch_seconds;
   assign rsp_ch.year_full     = date.year_full;
   assign rsp_ch.month_number  = date.month_number;
   assign rsp_ch.day_of_month  = date.day_of_month;
   assign rsp_ch.hour_bin      = tod.hour_bin;
   assign rsp_ch.minute_bin    = tod.minute_bin;
   assign rsp_ch.second_bin    = tod.second_bin;
   assign rsp_ch.time_present  = tod.time_present;
   assign rsp_ch.date_in_range = tod.date_in_range;

endmodule

### rtl/dmbtd_front.sv
// ----------------------------------------------------------------------------
// DVB MJD/BCD time decoder front stage
// Registers the request word with BCD digits decoded and the day of era set.
// ----------------------------------------------------------------------------
module dmbtd_front (
   input  logic                     clock,
   input  dmbtd_pkg::pipe_ctrl_type ctrl,
   input  logic [15:0]              julian_day,
   input  logic [7:0]               hour_bcd,
   input  logic [7:0]               minute_bcd,
   input  logic [7:0]               second_bcd,
   output dmbtd_pkg::front_type     front
);

   dmbtd_pkg::front_type front_ff;
   dmbtd_pkg::front_type front_in;

   always_comb begin
      front_in.julian_day = julian_day;
      front_in.era        = (julian_day >= dmbtd_pkg::MJD_ERA_ONE);
      // Days since the start of the current 400-year cycle.
      if (front_in.era) begin
         front_in.doe = {2'b00, julian_day} - {2'b00, dmbtd_pkg::MJD_ERA_ONE};
      end else begin
         front_in.doe = {2'b00, julian_day} + dmbtd_pkg::DOE_ERA_ZERO_ADD;
      end
      front_in.hour_bin      = dmbtd_pkg::bcd_to_bin(hour_bcd);
      front_in.minute_bin    = dmbtd_pkg::bcd_to_bin(minute_bcd);
      front_in.second_bin    = dmbtd_pkg::bcd_to_bin(second_bcd);
      front_in.time_present  = !((julian_day == 16'hFFFF) && (hour_bcd == 8'hFF)
                                 && (minute_bcd == 8'hFF) && (second_bcd == 8'hFF));
      front_in.date_in_range = (julian_day >= dmbtd_pkg::MJD_FORMULA_MIN);
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[0]) begin
         front_ff <= front_in;
      end
   end

   assign front = front_ff;

endmodule

### rtl/dmbtd_date.sv
// ----------------------------------------------------------------------------
// DVB MJD/BCD time decoder date path
// Day of cycle to Gregorian year, month and day over six register stages.
// ----------------------------------------------------------------------------
module dmbtd_date (
   input  logic                     clock,
   input  dmbtd_pkg::pipe_ctrl_type ctrl,
   input  dmbtd_pkg::front_type     front,
   output dmbtd_pkg::date_type      date
);

   // Stage 1: century leap corrections and the reciprocal product for /1460.
   logic [35:0] p1_ff;
   logic [2:0]  cent_ff;
   logic        last_ff;
   logic [17:0] doe1_ff;
   logic        era1_ff;
   // Stage 2: day count with leap days removed.
   logic [17:0] v2_ff;
   logic [17:0] doe2_ff;
   logic        era2_ff;
   // Stage 3: reciprocal product for /365.
   logic [35:0] p3_ff;
   logic [17:0] doe3_ff;
   logic        era3_ff;
   // Stage 4: year of cycle and day of year.
   logic [8:0]  yoe4_ff;
   logic [8:0]  doy4_ff;
   logic        era4_ff;
   // Stage 5: reciprocal product for /153 and the March-based year.
   logic [22:0] p5_ff;
   logic [8:0]  doy5_ff;
   logic [10:0] year5_ff;
   // Stage 6: output.
   dmbtd_pkg::date_type date_ff;

   logic [35:0] p1_in;
   logic [2:0]  cent_in;
   logic [6:0]  q1460;
   logic [17:0] v2_in;
   logic [35:0] p3_in;
   logic [8:0]  yoe_q;
   logic [1:0]  c100;
   logic [17:0] yday_base;
   logic [8:0]  doy4_in;
   logic [10:0] x153;
   logic [22:0] p5_in;
   logic [10:0] year5_in;
   logic [3:0]  mp;
   logic [3:0]  month_calc;
   dmbtd_pkg::date_type date_in;

   always_comb begin
      p1_in   = 36'(front.doe) * 36'(dmbtd_pkg::DIV1460_MUL);
      cent_in = 3'(front.doe >= dmbtd_pkg::DAYS_PER_CENTURY)
              + 3'(front.doe >= 18'(2 * dmbtd_pkg::DAYS_PER_CENTURY))
              + 3'(front.doe >= 18'(3 * dmbtd_pkg::DAYS_PER_CENTURY))
              + 3'(front.doe >= 18'(4 * dmbtd_pkg::DAYS_PER_CENTURY));

      q1460 = p1_ff[dmbtd_pkg::DIV1460_SHIFT +: 7];
      v2_in = doe1_ff - 18'(q1460) + 18'(cent_ff) - 18'(last_ff);

      p3_in = 36'(v2_ff) * 36'(dmbtd_pkg::DIV365_MUL);

      yoe_q     = p3_ff[dmbtd_pkg::DIV365_SHIFT +: 9];
      c100      = 2'(yoe_q >= 9'd100) + 2'(yoe_q >= 9'd200) + 2'(yoe_q >= 9'd300);
      yday_base = 18'(18'(yoe_q) * 18'd365) + 18'(yoe_q >> 2) - 18'(c100);
      doy4_in   = 9'(doe3_ff - yday_base);

      x153     = 11'(11'(doy4_ff) * 11'd5) + 11'd2;
      p5_in    = 23'(x153) * 23'(dmbtd_pkg::DIV153_MUL);
      year5_in = dmbtd_pkg::YEAR_BASE + (era4_ff ? dmbtd_pkg::YEARS_PER_ERA : 11'd0)
               + 11'(yoe4_ff);

      mp = p5_ff[dmbtd_pkg::DIV153_SHIFT +: 4];
      // Months are counted from March; January and February close the year.
      if (mp < 4'd10) begin
         month_calc = mp + 4'd3;
      end else begin
         month_calc = mp - 4'd9;
      end
      date_in.month_number = month_calc;
      date_in.day_of_month = 5'(doy5_ff - dmbtd_pkg::month_start(mp) + 9'd1);
      date_in.year_full    = year5_ff + 11'(month_calc <= 4'd2);
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[1]) begin
         p1_ff   <= p1_in;
         cent_ff <= cent_in;
         last_ff <= (front.doe == dmbtd_pkg::DAYS_PER_ERA_M1);
         doe1_ff <= front.doe;
         era1_ff <= front.era;
      end
      if (ctrl.load[2]) begin
         v2_ff   <= v2_in;
         doe2_ff <= doe1_ff;
         era2_ff <= era1_ff;
      end
      if (ctrl.load[3]) begin
         p3_ff   <= p3_in;
         doe3_ff <= doe2_ff;
         era3_ff <= era2_ff;
      end
      if (ctrl.load[4]) begin
         yoe4_ff <= yoe_q;
         doy4_ff <= doy4_in;
         era4_ff <= era3_ff;
      end
      if (ctrl.load[5]) begin
         p5_ff    <= p5_in;
         doy5_ff  <= doy4_ff;
         year5_ff <= year5_in;
      end
      if (ctrl.load[6]) begin
         date_ff <= date_in;
      end
   end

   assign date = date_ff;

endmodule

### rtl/dmbtd_time.sv
// ----------------------------------------------------------------------------
// DVB MJD/BCD time decoder epoch path
// Epoch seconds from the day count and time of day, aligned to the date path.
// ----------------------------------------------------------------------------
module dmbtd_time (
   input  logic                     clock,
   input  dmbtd_pkg::pipe_ctrl_type ctrl,
   input  dmbtd_pkg::cfg_type       cfg,
   input  dmbtd_pkg::front_type     front,
   output dmbtd_pkg::time_type      tod
);

   localparam int LAST = dmbtd_pkg::NUM_STAGES - 1;

   logic signed [33:0] prod_ff;
   logic [19:0]        secs_ff;
   logic signed [32:0] epoch_ff [LAST:2];
   logic [7:0]         hour_ff [LAST:1];
   logic [7:0]         minute_ff [LAST:1];
   logic [7:0]         second_ff [LAST:1];
   logic               present_ff [LAST:1];
   logic               in_range_ff [LAST:1];

   logic signed [16:0] dayoff;
   logic signed [33:0] prod_in;
   logic [19:0]        secs_in;
   logic signed [33:0] zone_ext;
   logic signed [33:0] sum;
   logic signed [32:0] epoch_in;

   always_comb begin
      dayoff  = $signed({1'b0, front.julian_day}) - $signed(dmbtd_pkg::MJD_UNIX_EPOCH);
      prod_in = 34'(dayoff) * $signed(dmbtd_pkg::SECONDS_PER_DAY);
      secs_in = 20'(20'(front.hour_bin) * 20'd3600) + 20'(20'(front.minute_bin) * 20'd60)
              + 20'(front.second_bin);

      zone_ext = cfg.local_mode ? 34'sd0 : 34'(cfg.zone_west_seconds);
      sum      = prod_ff + $signed(34'(secs_ff)) + zone_ext;
      epoch_in = present_ff[1] ? 33'(sum) : 33'sd0;
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[1]) begin
         prod_ff        <= prod_in;
         secs_ff        <= secs_in;
         hour_ff[1]     <= front.hour_bin;
         minute_ff[1]   <= front.minute_bin;
         second_ff[1]   <= front.second_bin;
         present_ff[1]  <= front.time_present;
         in_range_ff[1] <= front.date_in_range;
      end
      if (ctrl.load[2]) begin
         epoch_ff[2] <= epoch_in;
      end
      for (int k = 2; k <= LAST; k++) begin
         if (ctrl.load[k]) begin
            hour_ff[k]     <= hour_ff[k-1];
            minute_ff[k]   <= minute_ff[k-1];
            second_ff[k]   <= second_ff[k-1];
            present_ff[k]  <= present_ff[k-1];
            in_range_ff[k] <= in_range_ff[k-1];
         end
      end
      for (int k = 3; k <= LAST; k++) begin
         if (ctrl.load[k]) begin
            epoch_ff[k] <= epoch_ff[k-1];
         end
      end
   end

   assign tod.epoch_seconds = epoch_ff[LAST];
   assign tod.hour_bin      = hour_ff[LAST];
   assign tod.minute_bin    = minute_ff[LAST];
   assign tod.second_bin    = second_ff[LAST];
   assign tod.time_present  = present_ff[LAST];
   assign tod.date_in_range = in_range_ff[LAST];

endmodule

### rtl/dmbtd_checker.sv
// ----------------------------------------------------------------------------
// DVB MJD/BCD time decoder checker
// Port-level assertions on the decoder, attached to the top level by bind.
// ----------------------------------------------------------------------------
module dmbtd_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic signed [32:0] rsp_epoch_seconds,
   input logic [10:0]       rsp_year_full,
   input logic [3:0]        rsp_month_number,
   input logic [4:0]        rsp_day_of_month,
   input logic              rsp_time_present,
   input logic              rsp_date_in_range
);

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response word valid after reset");

   // A stalled response word holds.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_epoch_seconds)
                                  && $stable(rsp_year_full) && $stable(rsp_day_of_month))
      else $error("stalled response word changed");

   // The no-time code gives a zero epoch.
   a_no_time_epoch: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_time_present |-> rsp_epoch_seconds == 33'sd0)
      else $error("epoch not zero for undefined time");

   // Early dates lie before March 1900, and every date is a plausible one.
   a_date_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_date_in_range || rsp_year_full <= 11'd1900)
                    && rsp_month_number >= 4'd1 && rsp_month_number <= 4'd12
                    && rsp_day_of_month >= 5'd1)
      else $error("decoded date out of shape");

endmodule

bind dvb_mjd_bcd_time_decoder_unit dmbtd_checker u_dmbtd_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_epoch_seconds (rsp_ch.epoch_seconds),
   .rsp_year_full     (rsp_ch.year_full),
   .rsp_month_number  (rsp_ch.month_number),
   .rsp_day_of_month  (rsp_ch.day_of_month),
   .rsp_time_present  (rsp_ch.time_present),
   .rsp_date_in_range (rsp_ch.date_in_range)
);

### verif/tb_dvb_mjd_bcd_time_decoder_unit.sv
// ----------------------------------------------------------------------------
// DVB MJD/BCD time decoder testbench
// Drives UTC_time words into the decoder under several zone and mode settings
// and checks every response word against a behavioral decoder of its own.
// Both channels idle at random, and words marked to drain first wait for an empty pipeline.
// ----------------------------------------------------------------------------
module tb_dvb_mjd_bcd_time_decoder_unit;

   localparam int unsigned CYCLE_LIMIT    = 800000;
   localparam int unsigned RANDOM_PHASES  = 8;
   localparam int unsigned PHASE_WORDS    = 112;
   localparam int unsigned MAX_REPORTS    = 10;
   localparam longint      UNIX_EPOCH_MJD = 40587;
   localparam longint      DAY_SECONDS    = 86400;
   localparam longint unsigned FORMULA_FIRST_MJD = 15079;
   localparam longint unsigned MJD0_CIVIL_DAYS   = 678881;

   typedef struct {
      logic [15:0] julian_day;
      logic [7:0]  hour_bcd;
      logic [7:0]  minute_bcd;
      logic [7:0]  second_bcd;
      bit          drain_first;
   } time_field_type;

   typedef struct packed {
      logic signed [32:0] epoch_seconds;
      logic [10:0]        year_full;
      logic [3:0]         month_number;
      logic [4:0]         day_of_month;
      logic [7:0]         hour_bin;
      logic [7:0]         minute_bin;
      logic [7:0]         second_bin;
      logic               time_present;
      logic               date_in_range;
   } decoded_time_type;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic        csr_index;
   logic [16:0] csr_wdata;

   dmbtd_req_if req_ch ();
   dmbtd_rsp_if rsp_ch ();

   dvb_mjd_bcd_time_decoder_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Shadow copies of the two registers.
   logic signed [16:0] zone_shadow;
   logic               local_mode_shadow;

   time_field_type   pending_words [$];
   decoded_time_type decoded_due [$];

   int unsigned cycle_count;
   int unsigned error_count;
   int unsigned words_sent;
   int unsigned results_checked;
   int unsigned no_time_results;
   int unsigned early_results;
   int unsigned settings_used;
   int unsigned tx_gap;
   int unsigned tx_calm;
   int unsigned rx_stall;
   int unsigned rx_calm;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic longint unsigned bcd_value(input logic [7:0] b);
      return longint'(b[7:4]) * 10 + longint'(b[3:0]);
   endfunction

   function automatic decoded_time_type decode_time(input time_field_type w);
      decoded_time_type r;
      longint unsigned mjd, hh, mi, ss;
      longint unsigned yp, tt, mp, mm, kk, yr, mon, dd;
      longint unsigned z, era, doe, yoe, doy, mq;
      longint          ep;
      bit              present, in_rng;
      mjd = w.julian_day;
      hh = bcd_value(w.hour_bcd);
      mi = bcd_value(w.minute_bcd);
      ss = bcd_value(w.second_bcd);
      present = !(w.julian_day == 16'hFFFF && w.hour_bcd == 8'hFF &&
                  w.minute_bcd == 8'hFF && w.second_bcd == 8'hFF);
      in_rng = (mjd >= FORMULA_FIRST_MJD);
      if (in_rng) begin
         yp = (20 * mjd - 301564) / 7305;
         tt = (1461 * yp) / 4;
         mp = (10000 * (mjd - 14956 - tt) - 1000) / 306001;
         mm = (3060001 * mp) / 100000;
         kk = (mp == 14 || mp == 15) ? 1 : 0;
         dd = mjd - 14956 - tt - mm;
         yr = yp + kk + 1900;
         mon = mp - 1 - 12 * kk;
      end else begin
         // Exact Gregorian conversion, days counted from 0000-03-01.
         z = mjd + MJD0_CIVIL_DAYS;
         era = z / 146097;
         doe = z - era * 146097;
         yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
         doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
         mq = (5 * doy + 2) / 153;
         yr = yoe + era * 400;
         dd = doy - (153 * mq + 2) / 5 + 1;
         mon = (mq < 10) ? mq + 3 : mq - 9;
         if (mon <= 2) yr = yr + 1;
      end
      ep = 0;
      if (present) begin
         ep = (longint'(mjd) - UNIX_EPOCH_MJD) * DAY_SECONDS +
              longint'(hh * 3600 + mi * 60 + ss);
         if (!local_mode_shadow) ep = ep + longint'(zone_shadow);
      end
      r.epoch_seconds = ep[32:0];
      r.year_full     = yr[10:0];
      r.month_number  = mon[3:0];
      r.day_of_month  = dd[4:0];
      r.hour_bin      = hh[7:0];
      r.minute_bin    = mi[7:0];
      r.second_bin    = ss[7:0];
      r.time_present  = present;
      r.date_in_range = in_rng;
      return r;
   endfunction

   function automatic string show_time(input decoded_time_type r);
      return $sformatf("epoch=%0d date=%0d-%0d-%0d time=%0d:%0d:%0d present=%0b in_range=%0b",
                       $signed(r.epoch_seconds), r.year_full, r.month_number,
                       r.day_of_month, r.hour_bin, r.minute_bin, r.second_bin,
                       r.time_present, r.date_in_range);
   endfunction

   // Mostly short gaps, now and then a long one.
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic push_word(input logic [15:0] mjd, input logic [7:0] hb,
                            input logic [7:0] mb, input logic [7:0] sb,
                            input bit drain);
      time_field_type w;
      w.julian_day  = mjd;
      w.hour_bcd    = hb;
      w.minute_bcd  = mb;
      w.second_bcd  = sb;
      w.drain_first = drain;
      pending_words.push_back(w);
   endtask

   // Registers change only with the pipeline empty.
   task automatic set_config(input logic signed [16:0] zone, input logic lm);
      while (pending_words.size() != 0 || req_ch.valid || decoded_due.size() != 0)
         @(posedge clock);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= dmbtd_pkg::CSR_ZONE_WEST_SECONDS;
      csr_wdata <= zone;
      @(posedge clock);
      csr_index <= dmbtd_pkg::CSR_LOCAL_MODE;
      csr_wdata <= {16'd0, lm};
      @(posedge clock);
      csr_we <= 1'b0;
      zone_shadow       = zone;
      local_mode_shadow = lm;
      settings_used++;
   endtask

   // Request driver.
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            decoded_due.push_back(decode_time(pending_words[0]));
            void'(pending_words.pop_front());
            words_sent++;
            if (tx_calm > 0) begin
               tx_calm--;
               tx_gap = 0;
            end else begin
               tx_gap = pick_gap();
               if ($urandom_range(0, 49) == 0) tx_calm = $urandom_range(30, 100);
            end
         end
         if (req_ch.valid && !req_ch.ready) begin
            // Hold the word until it is taken.
         end else if (tx_gap > 0) begin
            tx_gap--;
            req_ch.valid <= 1'b0;
         end else if (pending_words.size() != 0 &&
                      !(pending_words[0].drain_first && decoded_due.size() != 0)) begin
            req_ch.valid      <= 1'b1;
            req_ch.julian_day <= pending_words[0].julian_day;
            req_ch.hour_bcd   <= pending_words[0].hour_bcd;
            req_ch.minute_bcd <= pending_words[0].minute_bcd;
            req_ch.second_bcd <= pending_words[0].second_bcd;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Response monitor and checker.
   always @(posedge clock) begin
      decoded_time_type got, want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.epoch_seconds = rsp_ch.epoch_seconds;
            got.year_full     = rsp_ch.year_full;
            got.month_number  = rsp_ch.month_number;
            got.day_of_month  = rsp_ch.day_of_month;
            got.hour_bin      = rsp_ch.hour_bin;
            got.minute_bin    = rsp_ch.minute_bin;
            got.second_bin    = rsp_ch.second_bin;
            got.time_present  = rsp_ch.time_present;
            got.date_in_range = rsp_ch.date_in_range;
            if (decoded_due.size() == 0) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $display("Unexpected response word: %s", show_time(got));
            end else begin
               want = decoded_due.pop_front();
               results_checked++;
               if (!want.time_present) no_time_results++;
               if (!want.date_in_range) early_results++;
               if (got !== want) begin
                  error_count++;
                  if (error_count <= MAX_REPORTS) begin
                     $display("Mismatch on response word %0d", results_checked);
                     $display("  expected %s", show_time(want));
                     $display("  actual   %s", show_time(got));
                  end
               end
            end
         end
         if (rx_stall > 0) begin
            rx_stall--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
            if (rx_calm > 0) begin
               rx_calm--;
            end else if ($urandom_range(0, 3) == 0) begin
               rx_stall = pick_gap();
               if ($urandom_range(0, 49) == 0) rx_calm = $urandom_range(40, 150);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d words still expected",
                  cycle_count, decoded_due.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      logic signed [16:0] zone_set [RANDOM_PHASES];
      logic               mode_set [RANDOM_PHASES];
      logic [15:0]        mjd;
      logic [7:0]         hb, mb, sb;
      int unsigned        kind;
      zone_set = '{17'sd0, -17'sd50400, 17'sd43200, 17'sd43200,
                   -17'sd65536, 17'sd65535, 17'sd0, 17'sd0};
      mode_set = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0};
      clock = 1'b0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = dmbtd_pkg::CSR_ZONE_WEST_SECONDS;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.julian_day = '0;
      req_ch.hour_bcd = '0;
      req_ch.minute_bcd = '0;
      req_ch.second_bcd = '0;
      rsp_ch.ready = 1'b0;
      zone_shadow = '0;
      local_mode_shadow = 1'b0;
      cycle_count = 0;
      error_count = 0;
      words_sent = 0;
      results_checked = 0;
      no_time_results = 0;
      early_results = 0;
      settings_used = 1;
      tx_gap = 0;
      tx_calm = 0;
      rx_stall = 0;
      rx_calm = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed words under the reset settings.
      push_word(16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);   // no time
      push_word(16'd0,     8'h00, 8'h00, 8'h00, 1'b0);  // earliest date
      push_word(16'hFFFF, 8'h00, 8'h00, 8'h00, 1'b0);   // latest date, present
      push_word(16'hFFFF, 8'hFF, 8'hFF, 8'hFE, 1'b0);   // largest epoch
      push_word(16'hFFFE, 8'hFF, 8'hFF, 8'hFF, 1'b0);
      push_word(16'd15078, 8'h23, 8'h59, 8'h59, 1'b0);  // last early day
      push_word(16'd15079, 8'h00, 8'h00, 8'h00, 1'b0);  // first formula day
      push_word(16'd14956, 8'h01, 8'h02, 8'h03, 1'b0);
      push_word(16'd15385, 8'h00, 8'h00, 8'h01, 1'b0);
      push_word(16'd40587, 8'h00, 8'h00, 8'h00, 1'b0);  // Unix epoch
      push_word(16'd51603, 8'h12, 8'h34, 8'h56, 1'b0);  // leap day 2000
      push_word(16'd51604, 8'h00, 8'h00, 8'h00, 1'b0);
      push_word(16'd45000, 8'h99, 8'h99, 8'h99, 1'b0);
      push_word(16'd45000, 8'hAF, 8'hFA, 8'hF0, 1'b0);  // non-BCD digits
      push_word(16'd0,     8'hFF, 8'hFF, 8'hFF, 1'b0);
      push_word(16'd59000, 8'h23, 8'h59, 8'h59, 1'b1);  // after a full drain
      push_word(16'd60000, 8'h10, 8'h20, 8'h30, 1'b0);
      push_word(16'd58848, 8'h05, 8'h4A, 8'h0B, 1'b0);

      set_config(-17'sd50400, 1'b0);
      push_word(16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
      push_word(16'd0,     8'h00, 8'h00, 8'h00, 1'b0);
      push_word(16'hFFFF, 8'hFF, 8'hFF, 8'hFE, 1'b0);
      set_config(17'sd43200, 1'b1);
      push_word(16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
      push_word(16'd0,     8'h00, 8'h00, 8'h00, 1'b0);
      push_word(16'hFFFF, 8'hFF, 8'hFF, 8'hFE, 1'b0);

      for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
         if (p >= 6) begin
            zone_set[p] = 17'($urandom);
            mode_set[p] = 1'($urandom_range(0, 1));
         end
         set_config(zone_set[p], mode_set[p]);
         for (int unsigned i = 0; i < PHASE_WORDS; i++) begin
            kind = $urandom_range(0, 99);
            mjd = 16'($urandom_range(15079, 65535));
            hb = {4'($urandom_range(0, 2)), 4'($urandom_range(0, 9))};
            mb = {4'($urandom_range(0, 5)), 4'($urandom_range(0, 9))};
            sb = {4'($urandom_range(0, 5)), 4'($urandom_range(0, 9))};
            if (kind >= 55 && kind < 70) begin
               mjd = 16'($urandom_range(0, 15078));
            end else if (kind >= 70 && kind < 85) begin
               mjd = 16'($urandom);
               hb = 8'($urandom);
               mb = 8'($urandom);
               sb = 8'($urandom);
            end else if (kind >= 85 && kind < 90) begin
               mjd = 16'hFFFF;
               hb = 8'hFF;
               mb = 8'hFF;
               sb = 8'hFF;
            end else if (kind >= 90 && kind < 95) begin
               // Around the formula boundary, the Unix epoch or the top of the range.
               case ($urandom_range(0, 2))
                  0: mjd = 16'($urandom_range(15068, 15090));
                  1: mjd = 16'($urandom_range(40580, 40594));
                  default: mjd = 16'($urandom_range(65525, 65535));
               endcase
               hb = 8'($urandom);
               sb = 8'($urandom);
            end else if (kind >= 95) begin
               // One byte away from the no-time pattern.
               mjd = 16'hFFFF;
               hb = 8'hFF;
               mb = 8'hFF;
               sb = 8'hFF;
               case ($urandom_range(0, 3))
                  0: mjd[4'($urandom_range(0, 15))] = 1'b0;
                  1: hb = 8'($urandom_range(0, 254));
                  2: mb = 8'($urandom_range(0, 254));
                  default: sb = 8'($urandom_range(0, 254));
               endcase
            end
            push_word(mjd, hb, mb, sb, ($urandom_range(0, 59) == 0));
         end
      end

      while (pending_words.size() != 0 || req_ch.valid || decoded_due.size() != 0)
         @(posedge clock);
      repeat (dmbtd_pkg::NUM_STAGES * 3) @(posedge clock);
      $display("Sent %0d words under %0d register settings; checked %0d responses",
               words_sent, settings_used, results_checked);
      $display("of which %0d carried no time and %0d had dates before 1900-03-01",
               no_time_results, early_results);
      if (error_count == 0 && decoded_due.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d errors", error_count);
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

### sim.f
rtl/dmbtd_pkg.sv
rtl/dmbtd_channels.sv
rtl/dmbtd_front.sv
rtl/dmbtd_date.sv
rtl/dmbtd_time.sv
rtl/dvb_mjd_bcd_time_decoder_unit.sv
rtl/dmbtd_checker.sv
verif/tb_dvb_mjd_bcd_time_decoder_unit.sv
